@@ src/range_median_filter5_defines.svh @@
// Assertion macros for the range median filter.
`ifndef RANGE_MEDIAN_FILTER5_DEFINES_SVH
`define RANGE_MEDIAN_FILTER5_DEFINES_SVH

`ifndef SYNTH

`define RMF5_ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("rmf5 assertion failed");

`define RMF5_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("rmf5 assertion failed");

`else

`define RMF5_ASSERT_IMPLIES(label, clk, rst, cond, expr)

`define RMF5_ASSERT_NEXT(label, clk, rst, cond, expr)

`endif

`endif

@@ src/rmf5_pkg.sv @@
// Shared types and constants of the range median filter.
package rmf5_pkg;

   localparam int DISTANCE_WIDTH = 16;
   localparam int WINDOW         = 5;
   localparam int SLOT_WIDTH     = $clog2(WINDOW);
   localparam int OUT_WIDTH      = DISTANCE_WIDTH + 1;
   localparam int RSP_DATA_WIDTH = ((OUT_WIDTH + 7) / 8) * 8;

   typedef logic [DISTANCE_WIDTH-1:0] dist_type;
   typedef logic [SLOT_WIDTH-1:0]     slot_type;
   typedef dist_type                  window_type [WINDOW];

   localparam dist_type MAX_RANGE_RESET = dist_type'(400);
   localparam slot_type LAST_SLOT       = slot_type'(WINDOW - 1);
   localparam slot_type FIRST_SLOT      = slot_type'(0);

   typedef struct packed {
      logic     write;
      dist_type sample;
   } ring_req_type;

   typedef struct packed {
      logic full;
   } ring_status_type;

endpackage

@@ src/rmf5_ring.sv @@
// Five-entry sample ring with write slot and fill flag.
`include "range_median_filter5_defines.svh"

module rmf5_ring (
   input  logic                    clock,
   input  logic                    reset,
   input  rmf5_pkg::ring_req_type  req,
   output rmf5_pkg::window_type    samples_in,
   output rmf5_pkg::ring_status_type status_in
);

   rmf5_pkg::window_type samples_ff;
   rmf5_pkg::slot_type   slot_ff;
   rmf5_pkg::slot_type   slot_in;
   rmf5_pkg::slot_type   slot_cur;
   logic                 full_ff;
   logic                 full_in;

   always_comb begin
      slot_cur = (slot_ff > rmf5_pkg::LAST_SLOT) ? rmf5_pkg::FIRST_SLOT : slot_ff;
      slot_in  = slot_ff;
      full_in  = full_ff;
      for (int i = 0; i < rmf5_pkg::WINDOW; i++) begin
         samples_in[i] = samples_ff[i];
      end
      if (req.write) begin
         samples_in[slot_cur] = req.sample;
         if (slot_cur == rmf5_pkg::LAST_SLOT) begin
            slot_in = rmf5_pkg::FIRST_SLOT;
            full_in = 1'b1;
         end else begin
            slot_in = slot_cur + rmf5_pkg::slot_type'(1);
         end
      end
      status_in.full = full_in;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < rmf5_pkg::WINDOW; i++) begin
         samples_ff[i] <= samples_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= rmf5_pkg::FIRST_SLOT;
         full_ff <= 1'b0;
      end else begin
         slot_ff <= slot_in;
         full_ff <= full_in;
      end
   end

   `RMF5_ASSERT_IMPLIES(a_slot_bound, clock, reset, 1'b1, slot_ff <= rmf5_pkg::LAST_SLOT)
   `RMF5_ASSERT_NEXT(a_full_sticky, clock, reset, full_ff, full_ff)
   `RMF5_ASSERT_IMPLIES(a_full_on_wrap, clock, reset, !full_ff && full_in, req.write && slot_in == rmf5_pkg::FIRST_SLOT)

endmodule

@@ src/rmf5_median.sv @@
// Five-input median comparator network.
module rmf5_median (
   input  rmf5_pkg::window_type samples,
   output rmf5_pkg::dist_type   median
);

   rmf5_pkg::dist_type lo_ab;
   rmf5_pkg::dist_type hi_ab;
   rmf5_pkg::dist_type lo_cd;
   rmf5_pkg::dist_type hi_cd;
   rmf5_pkg::dist_type mid_lo;
   rmf5_pkg::dist_type mid_hi;
   rmf5_pkg::dist_type min_mid;
   rmf5_pkg::dist_type max_mid;
   rmf5_pkg::dist_type clip_e;

   always_comb begin
      lo_ab   = (samples[0] < samples[1]) ? samples[0] : samples[1];
      hi_ab   = (samples[0] < samples[1]) ? samples[1] : samples[0];
      lo_cd   = (samples[2] < samples[3]) ? samples[2] : samples[3];
      hi_cd   = (samples[2] < samples[3]) ? samples[3] : samples[2];
      // drop the smallest and largest of the first four
      mid_lo  = (lo_ab > lo_cd) ? lo_ab : lo_cd;
      mid_hi  = (hi_ab < hi_cd) ? hi_ab : hi_cd;
      min_mid = (mid_lo < mid_hi) ? mid_lo : mid_hi;
      max_mid = (mid_lo < mid_hi) ? mid_hi : mid_lo;
      clip_e  = (max_mid < samples[4]) ? max_mid : samples[4];
      median  = (min_mid > clip_e) ? min_mid : clip_e;
   end

endmodule

@@ src/range_median_filter5.sv @@
// Path: a request is registered in stage 1, then its result in the result
// register, which drives rsp_tvalid; a stalled output holds stage 1.
// Throughput: one transaction per cycle while rsp_tready does not stall the result;
// input register, ring update and median network, then result register.
// Reset: synchronous, active high; clears the write slot, the fill flag and
// both valid flags, and loads max_range_cm with 400. Ring entries are not reset.
module range_median_filter5 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [15:0] raw_distance
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [rmf5_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata, // [16:0] filtered_distance, rest 0
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data    // [15:0] max_range_cm
);

   rmf5_pkg::dist_type        max_range_ff;
   logic                      s1_valid_ff;
   rmf5_pkg::dist_type        s1_reading_ff;
   logic                      s1_in_range_ff;
   logic                      rsp_valid_ff;
   logic signed [rmf5_pkg::OUT_WIDTH-1:0] rsp_data_ff;
   logic signed [rmf5_pkg::OUT_WIDTH-1:0] rsp_data_in;
   logic                      out_free;
   logic                      s1_advance;
   logic                      req_accept;
   rmf5_pkg::ring_req_type    ring_req;
   rmf5_pkg::window_type      ring_samples;
   rmf5_pkg::ring_status_type ring_status;
   rmf5_pkg::dist_type        median;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_advance = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign ring_req.write  = s1_advance && s1_in_range_ff;
   assign ring_req.sample = s1_reading_ff;

   rmf5_ring u_ring (
      .clock      (clock),
      .reset      (reset),
      .req        (ring_req),
      .samples_in (ring_samples),
      .status_in  (ring_status)
   );

   rmf5_median u_median (
      .samples (ring_samples),
      .median  (median)
   );

   always_comb begin
      if (ring_status.full) begin
         rsp_data_in = {1'b0, median};
      end else if (s1_in_range_ff) begin
         rsp_data_in = {1'b0, s1_reading_ff};
      end else begin
         rsp_data_in = '1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_range_ff <= rmf5_pkg::MAX_RANGE_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            max_range_ff <= csr_data;
         end
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_reading_ff  <= req_tdata;
         s1_in_range_ff <= (req_tdata <= max_range_ff);
      end
      if (s1_advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(rmf5_pkg::RSP_DATA_WIDTH - rmf5_pkg::OUT_WIDTH){1'b0}}, rsp_data_ff};

endmodule
